// File: rtl/subscriber_slot_table_macros.svh
// assertion helpers on clk, disabled during reset
`ifndef SUBSCRIBER_SLOT_TABLE_MACROS_SVH
`define SUBSCRIBER_SLOT_TABLE_MACROS_SVH

// same-cycle implication
`define SST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot table check failed");

// next-cycle implication
`define SST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot table check failed");

`endif

// File: rtl/sst_pkg.sv
package sst_pkg;

	localparam int REQ_W       = 2;
	localparam int ROW_IN_W    = 4;
	localparam int SUB_ID_W    = 16;
	localparam int MATCHED_W   = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd2;

	typedef struct packed {
		logic                 success;
		logic [MATCHED_W-1:0] matched_id;
	} result_t;

endpackage

// File: rtl/subscriber_slot_table.sv
// Subscriber slot table: ROW_COUNT rows of SLOTS_PER_ROW ids, one insert, remove or
// check item per clock while m_tready allows, each passing the s1 stage and then the
// output register. The rate is set by the row store, whose one read port delivers a
// whole row registered; the row is then matched and rewritten, with a write to the
// same row forwarded to the next item. Reset empties the table at once through
// one valid bit per row, so there is no clearing pass and items are taken right away.
// An output register lets a new item enter while a result waits to be taken.
`include "subscriber_slot_table_macros.svh"

module subscriber_slot_table #(
	parameter int SLOTS_PER_ROW = 8,
	parameter int ROW_COUNT     = 16,
	parameter int ID_BITS       = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// req_type[1:0], row[5:2], sub_id[21:6], zero pad
	input  logic [sst_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// success[0], matched_id[16:1], zero pad
	output logic [sst_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	import sst_pkg::*;

	localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int DATA_W = SLOTS_PER_ROW * ID_BITS;

	logic [REQ_W-1:0]    in_req;
	logic [ROW_IN_W-1:0] in_row;
	logic [SUB_ID_W-1:0] in_sub_id;
	logic                in_range;

	logic                accept;
	logic                adv;
	logic                commit;

	logic                s1_valid_q;
	logic [REQ_W-1:0]    req_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [ID_BITS-1:0]  id_s1;
	logic                in_range_s1;

	logic [DATA_W-1:0]   row_data;
	logic [DATA_W-1:0]   wr_data;
	logic                wr_hit;
	logic                mem_wr;
	result_t             result;

	logic                out_valid_q;
	result_t             out_result_q;

	assign in_req    = s_tdata[REQ_W-1:0];
	assign in_row    = s_tdata[REQ_W +: ROW_IN_W];
	assign in_sub_id = s_tdata[REQ_W+ROW_IN_W +: SUB_ID_W];
	assign in_range  = (int'(in_row) < ROW_COUNT);

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || adv;
	assign accept   = s_tvalid && s_tready;
	assign commit   = s1_valid_q && adv;
	assign mem_wr   = commit && wr_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= in_req;
			row_s1      <= ROW_W'(in_row);
			id_s1       <= ID_BITS'(in_sub_id);
			in_range_s1 <= in_range;
		end
	end

	sst_row_store #(
		.ROW_COUNT (ROW_COUNT),
		.ROW_W     (ROW_W),
		.DATA_W    (DATA_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (ROW_W'(in_row)),
		.wr_en   (mem_wr),
		.wr_idx  (row_s1),
		.wr_data (wr_data),
		.rd_data (row_data)
	);

	sst_row_logic #(
		.SLOTS_PER_ROW (SLOTS_PER_ROW),
		.ID_BITS       (ID_BITS)
	) u_logic (
		.req_type (req_s1),
		.in_range (in_range_s1),
		.id       (id_s1),
		.row_data (row_data),
		.wr_en    (wr_hit),
		.wr_data  (wr_data),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-1-MATCHED_W){1'b0}},
		out_result_q.matched_id, out_result_q.success};

	`SST_ASSERT_NEXT(a_commit_gives_result, commit, out_valid_q)
	`SST_ASSERT_NOW(a_fail_no_id, out_valid_q && !out_result_q.success,
		out_result_q.matched_id == '0)
	`SST_ASSERT_NOW(a_write_only_update, mem_wr,
		in_range_s1 && (req_s1 == REQ_INSERT || req_s1 == REQ_REMOVE))

endmodule

// File: rtl/sst_row_store.sv
module sst_row_store #(
	parameter int ROW_COUNT = 16,
	parameter int ROW_W     = 4,
	parameter int DATA_W    = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ROW_W-1:0]  rd_idx,
	input  logic              wr_en,
	input  logic [ROW_W-1:0]  wr_idx,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0]    mem [ROW_COUNT];
	logic [ROW_COUNT-1:0] row_valid_q;
	logic [DATA_W-1:0]    rd_raw_s1;
	logic [DATA_W-1:0]    byp_data_s1;
	logic                 byp_s1;
	logic                 rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_s1   <= mem[rd_idx];
			byp_data_s1 <= wr_data;
		end
	end

	// per-row valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			byp_s1      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				byp_s1      <= wr_en && (wr_idx == rd_idx);
				rd_valid_s1 <= row_valid_q[rd_idx];
			end
		end
	end

	assign rd_data = byp_s1 ? byp_data_s1 : (rd_valid_s1 ? rd_raw_s1 : '0);

endmodule

// File: rtl/sst_row_logic.sv
module sst_row_logic #(
	parameter int SLOTS_PER_ROW = 8,
	parameter int ID_BITS       = 16
) (
	input  logic [sst_pkg::REQ_W-1:0]         req_type,
	input  logic                              in_range,
	input  logic [ID_BITS-1:0]                id,
	input  logic [SLOTS_PER_ROW*ID_BITS-1:0]  row_data,
	output logic                              wr_en,
	output logic [SLOTS_PER_ROW*ID_BITS-1:0]  wr_data,
	output sst_pkg::result_t                  result
);

	import sst_pkg::*;

	logic [SLOTS_PER_ROW-1:0] free_vec;
	logic [SLOTS_PER_ROW-1:0] hit_vec;
	logic [SLOTS_PER_ROW-1:0] free_first;
	logic [SLOTS_PER_ROW-1:0] hit_first;

	always_comb begin
		for (int s = 0; s < SLOTS_PER_ROW; s++) begin
			free_vec[s] = (row_data[s*ID_BITS +: ID_BITS] == '0);
			hit_vec[s]  = (row_data[s*ID_BITS +: ID_BITS] == id);
		end
	end

	// isolate lowest set bit
	assign free_first = free_vec & (~free_vec + SLOTS_PER_ROW'(1));
	assign hit_first  = hit_vec & (~hit_vec + SLOTS_PER_ROW'(1));

	always_comb begin
		wr_en   = 1'b0;
		wr_data = row_data;
		result  = '0;
		if (in_range) begin
			unique case (req_type)
				REQ_INSERT: begin
					result.success = |free_vec;
					wr_en          = |free_vec;
					for (int s = 0; s < SLOTS_PER_ROW; s++) begin
						if (free_first[s]) begin
							wr_data[s*ID_BITS +: ID_BITS] = id;
						end
					end
				end
				REQ_REMOVE: begin
					result.success = |hit_vec;
					wr_en          = |hit_vec;
					for (int s = 0; s < SLOTS_PER_ROW; s++) begin
						if (hit_first[s]) begin
							wr_data[s*ID_BITS +: ID_BITS] = '0;
						end
					end
				end
				REQ_CHECK: begin
					result.success = |hit_vec;
					if (|hit_vec) begin
						result.matched_id = MATCHED_W'(id);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: tb/subscriber_slot_table_tb.sv
`timescale 1ns / 1ps

module subscriber_slot_table_tb;

	import sst_pkg::*;

	localparam int                SLOTS      = 8;
	localparam int                ROWS       = 16;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int                RANDOM_REQS = 700;
	localparam int                POOL_SIZE   = 10;

	typedef struct packed {
		logic [SUB_ID_W-1:0] id;
		logic [ROW_IN_W-1:0] row;
		logic [REQ_W-1:0]    kind;
	} request_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	request_t        pending_reqs[$];
	result_t         expected_results[$];
	logic [SUB_ID_W-1:0] slot_table[ROWS][SLOTS];
	logic [SUB_ID_W-1:0] id_pool[POOL_SIZE];
	logic            req_taken;
	int              sent_count;
	int              total_reqs;
	int              errors;

	subscriber_slot_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("subscriber_slot_table_tb NOT OK");
		$finish;
	end

	// lowest slot holding a value, SLOTS if none
	function automatic int find_slot(int r, logic [SUB_ID_W-1:0] value);
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_table[r][s] == value)
				return s;
		end
		return SLOTS;
	endfunction

	// updates the table copy and returns the result the item gives
	function automatic result_t apply_request(request_t r);
		result_t res;
		int      s;
		res = '0;
		if (r.row < ROWS) begin
			case (r.kind)
				REQ_INSERT: begin
					s = find_slot(r.row, '0);
					if (s < SLOTS) begin
						slot_table[r.row][s] = r.id;
						res.success = 1'b1;
					end
				end
				REQ_REMOVE: begin
					s = find_slot(r.row, r.id);
					if (s < SLOTS) begin
						slot_table[r.row][s] = '0;
						res.success = 1'b1;
					end
				end
				REQ_CHECK: begin
					s = find_slot(r.row, r.id);
					if (s < SLOTS) begin
						res.success    = 1'b1;
						res.matched_id = r.id;
					end
				end
				default: ;
			endcase
		end
		return res;
	endfunction

	task automatic add_req(logic [REQ_W-1:0] kind, int r, logic [SUB_ID_W-1:0] id);
		request_t q;
		q.kind = kind;
		q.row  = r[ROW_IN_W-1:0];
		q.id   = id;
		pending_reqs.push_back(q);
	endtask

	// driver
	always @(negedge clk) begin : drive_proc
		request_t nxt;
		int       send_idle;
		int       recv_idle;
		if (arst_n) begin
			if (sent_count < total_reqs / 3) begin
				send_idle = 37;
				recv_idle = 65;
			end else if (sent_count < (2 * total_reqs) / 3) begin
				send_idle = 65;
				recv_idle = 37;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (!s_tvalid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					nxt = pending_reqs.pop_front();
					s_tdata  <= {{(IN_TDATA_W - $bits(request_t)){1'b0}}, nxt};
					s_tvalid <= 1'b1;
					sent_count++;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// input side: predict each accepted item
	always @(posedge clk) begin : input_mon
		request_t r;
		req_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			r = s_tdata[$bits(request_t)-1:0];
			expected_results.push_back(apply_request(r));
		end
	end

	// output side: compare against oldest expectation
	always @(posedge clk) begin : result_mon
		result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result item, got success %0b matched_id %h",
					$time, m_tdata[0], m_tdata[16:1]);
				errors++;
			end else begin
				exp_res = expected_results.pop_front();
				if (m_tdata[0] !== exp_res.success) begin
					$display("%0t: success mismatch, expected %0b got %0b",
						$time, exp_res.success, m_tdata[0]);
					errors++;
				end
				if (m_tdata[16:1] !== exp_res.matched_id) begin
					$display("%0t: matched_id mismatch, expected %h got %h",
						$time, exp_res.matched_id, m_tdata[16:1]);
					errors++;
				end
			end
		end
	end

	initial begin : main_proc
		int               pick;
		logic [REQ_W-1:0] kind;
		int               r;
		logic [SUB_ID_W-1:0] id;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		req_taken  = 1'b0;
		sent_count = 0;
		total_reqs = 0;
		errors     = 0;
		for (int i = 0; i < ROWS; i++)
			for (int s = 0; s < SLOTS; s++)
				slot_table[i][s] = '0;

		// directed part
		add_req(REQ_CHECK, 0, 16'd5);
		add_req(REQ_CHECK, 0, 16'd0);
		add_req(REQ_INSERT, 0, 16'hFFFF);
		add_req(REQ_INSERT, 0, 16'd1);
		add_req(REQ_INSERT, 0, 16'd2);
		add_req(REQ_INSERT, 0, 16'h8000);
		add_req(REQ_INSERT, 0, 16'd1);
		add_req(REQ_INSERT, 0, 16'h5555);
		add_req(REQ_INSERT, 0, 16'hAAAA);
		add_req(REQ_INSERT, 0, 16'd7);
		add_req(REQ_INSERT, 0, 16'd9);
		add_req(REQ_INSERT, 0, 16'd0);
		add_req(REQ_CHECK, 0, 16'd0);
		add_req(REQ_REMOVE, 0, 16'd0);
		add_req(REQ_CHECK, 0, 16'hFFFF);
		add_req(REQ_REMOVE, 0, 16'd1);
		add_req(REQ_CHECK, 0, 16'd1);
		add_req(REQ_REMOVE, 0, 16'd1);
		add_req(REQ_CHECK, 0, 16'd1);
		add_req(REQ_INSERT, 0, 16'd0);
		add_req(REQ_REMOVE, 0, 16'd0);
		add_req(REQ_UNUSED, 0, 16'hFFFF);
		add_req(REQ_INSERT, 15, 16'h4321);
		add_req(REQ_CHECK, 15, 16'h4321);
		add_req(REQ_REMOVE, 15, 16'd99);

		// random part: a few busy rows and a small id pool so rows fill and match
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = SUB_ID_W'($urandom_range(1, 16'hFFFF));
		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				kind = REQ_INSERT;
			else if (pick < 65)
				kind = REQ_REMOVE;
			else if (pick < 95)
				kind = REQ_CHECK;
			else
				kind = REQ_UNUSED;
			r = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, ROWS - 1);
			pick = $urandom_range(0, 99);
			if (pick < 75)
				id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (pick < 80)
				id = '0;
			else
				id = SUB_ID_W'($urandom_range(0, 16'hFFFF));
			add_req(kind, r, id);
		end
		total_reqs = pending_reqs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (10) @(negedge clk);

		if (errors == 0) begin
			$display("subscriber_slot_table_tb OK");
		end else begin
			$display("subscriber_slot_table_tb NOT OK");
		end
		$finish;
	end

endmodule

// File: subscriber_slot_table.f
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_row_store.sv
rtl/sst_row_logic.sv
rtl/subscriber_slot_table.sv
tb/subscriber_slot_table_tb.sv
